// ===== hw/rtl/dmwbc_pkg.sv =====
// shared types, constants and codes of the direct-mapped write-back cache
// no dependencies; compile first
package dmwbc_pkg;

    // default geometry
    localparam int NUM_LINES_DEF  = 32;
    localparam int LINE_BYTES_DEF = 8;
    localparam int ADDR_BITS_DEF  = 16;

    localparam int DATA_W = 8;

    // request type codes
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB,
        ST_FILL,
        ST_ACCESS,
        ST_RESP
    } dmwbc_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic req_load;
        logic flags_load;
        logic clr_en;
        logic cnt_inc;
        logic cnt_clr;
        logic lm_rd_en;
        logic lm_rd_walk;
        logic lm_wr_fill;
        logic lm_wr_req;
        logic st_rd_en;
        logic st_wr_wb;
        logic tag_wr;
        logic dirty_set;
        logic out_load;
    } dmwbc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic dirty;
        logic is_write;
        logic cnt_zero;
        logic cnt_last;
        logic out_free;
    } dmwbc_sts_t;

endpackage

// ===== hw/rtl/dmwbc_req_if.sv =====
// request channel: valid/ready with access type, byte address and write byte
// depends on dmwbc_pkg
interface dmwbc_req_if
    import dmwbc_pkg::*;
#(
    parameter int ADDR_W = ADDR_BITS_DEF
) ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output req_type, output address, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_data,
                    output ready);
endinterface

// ===== hw/rtl/dmwbc_rsp_if.sv =====
// response channel: valid/ready with read byte, hit flag and prior dirty bit
// depends on dmwbc_pkg
interface dmwbc_rsp_if
    import dmwbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              was_dirty;

    modport source (output valid, output read_data, output hit, output was_dirty,
                    input ready);
    modport sink   (input valid, input read_data, input hit, input was_dirty,
                    output ready);
endinterface

// ===== hw/rtl/direct_mapped_writeback_cache_unit.sv =====
// Direct-mapped write-back write-allocate byte cache with its own backing store
// of 2^ADDR_BITS bytes. After reset a clearing sweep writes zero to every store
// byte, one per cycle, so req.ready stays low until the sweep is done. One
// item at a time is worked: lookup, then the access of the line memory, and for
// a read the load of the output register; a clean miss adds a refill of the
// line and a dirty miss adds a write-back of the old line before the refill.
// Miss cost is set by the byte-wide single-port store and line memories, one
// byte moved per cycle. A write gives no result; a read gives one, held in an
// output register so a new item is taken while the result waits.
// depends on dmwbc_pkg, dmwbc_req_if, dmwbc_rsp_if, dmwbc_ctrl, dmwbc_datapath
module direct_mapped_writeback_cache_unit
    import dmwbc_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dmwbc_req_if.sink   req,
    dmwbc_rsp_if.source rsp
);

    dmwbc_cmd_t cmd;
    dmwbc_sts_t sts;

    // controller
    dmwbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    dmwbc_datapath #(
        .NUM_LINES  (NUM_LINES),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (req.req_type),
        .address    (req.address),
        .write_data (req.write_data),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .read_data  (rsp.read_data),
        .hit        (rsp.hit),
        .was_dirty  (rsp.was_dirty)
    );

endmodule

// ===== hw/rtl/dmwbc_ctrl.sv =====
// controller state machine: clearing sweep, lookup, write-back, refill, access
// depends on dmwbc_pkg; drives the datapath through dmwbc_cmd_t
module dmwbc_ctrl
    import dmwbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dmwbc_sts_t sts,
    output dmwbc_cmd_t cmd
);

    dmwbc_state_t state_reg;
    dmwbc_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.flags_load = 1'b1;
                if (sts.hit)
                begin
                    state_next = ST_ACCESS;
                end
                else if (sts.dirty)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_WB:
            begin
                // read line byte i, write store byte i-1
                cmd.lm_rd_en   = !sts.cnt_last;
                cmd.lm_rd_walk = 1'b1;
                cmd.st_wr_wb   = !sts.cnt_zero;
                if (sts.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_FILL;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_FILL:
            begin
                // read store byte i, write line byte i-1
                cmd.st_rd_en   = !sts.cnt_last;
                cmd.lm_wr_fill = !sts.cnt_zero;
                if (sts.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    cmd.tag_wr  = 1'b1;
                    state_next  = ST_ACCESS;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_ACCESS:
            begin
                if (sts.is_write)
                begin
                    cmd.lm_wr_req = 1'b1;
                    cmd.dirty_set = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.lm_rd_en = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a result is only loaded when the output register can take it
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");

    // tags only change once the refill has moved every byte
    a_tag_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tag_wr |-> sts.cnt_last && state_reg == ST_FILL)
        else $error("tag written before refill finished");

    // write-back only for a dirty line that missed
    a_wb_dirty_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && state_next == ST_WB) |-> sts.dirty && !sts.hit)
        else $error("write-back started for clean or hitting line");

    // an accepted item is looked up in the following cycle
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.req_load |=> state_reg == ST_LOOKUP)
        else $error("accepted item not looked up");

    // no item is taken while the memories are being cleared
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_en |-> !in_ready)
        else $error("item taken during clearing sweep");

endmodule

// ===== hw/rtl/dmwbc_datapath.sv =====
// datapath: request registers, tag and dirty arrays, line and store memories,
// byte counter, clearing sweep counter and output register; depends on dmwbc_pkg
module dmwbc_datapath
    import dmwbc_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dmwbc_cmd_t           cmd,
    output dmwbc_sts_t           sts,
    input  logic                 req_type,
    input  logic [ADDR_BITS-1:0] address,
    input  logic [DATA_W-1:0]    write_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [DATA_W-1:0]    read_data,
    output logic                 hit,
    output logic                 was_dirty
);

    localparam int OFF_W       = $clog2(LINE_BYTES);
    localparam int LINE_W      = $clog2(NUM_LINES);
    localparam int TAG_W       = ADDR_BITS - LINE_W - OFF_W;
    localparam int LM_W        = LINE_W + OFF_W;
    localparam int LM_DEPTH    = NUM_LINES * LINE_BYTES;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    localparam int CNT_W       = OFF_W + 1;

    // request registers
    logic                 req_write_reg;
    logic [ADDR_BITS-1:0] req_addr_reg;
    logic [DATA_W-1:0]    req_wdata_reg;

    logic [TAG_W-1:0]  req_tag;
    logic [LINE_W-1:0] req_line;
    logic [OFF_W-1:0]  req_off;

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_write_reg <= req_type;
            req_addr_reg  <= address;
            req_wdata_reg <= write_data;
        end
    end

    assign req_tag  = req_addr_reg[ADDR_BITS-1 -: TAG_W];
    assign req_line = req_addr_reg[OFF_W +: LINE_W];
    assign req_off  = req_addr_reg[OFF_W-1:0];

    // tag and dirty arrays
    logic [TAG_W-1:0]     tag_reg [NUM_LINES];
    logic [NUM_LINES-1:0] dirty_reg;
    logic [TAG_W-1:0]     old_tag;

    assign old_tag = tag_reg[req_line];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                tag_reg[i] <= '0;
            end
            dirty_reg <= '0;
        end
        else
        begin
            if (cmd.tag_wr)
            begin
                tag_reg[req_line]   <= req_tag;
                dirty_reg[req_line] <= 1'b0;
            end
            else if (cmd.dirty_set)
            begin
                dirty_reg[req_line] <= 1'b1;
            end
        end
    end

    // hit and prior dirty flags for the response
    logic flag_hit_reg;
    logic flag_dirty_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.flags_load)
        begin
            flag_hit_reg   <= (old_tag == req_tag);
            flag_dirty_reg <= dirty_reg[req_line];
        end
    end

    // byte counter for write-back and refill
    logic [CNT_W-1:0] cnt_reg;
    logic [OFF_W-1:0] cnt_lo;
    logic [OFF_W-1:0] cnt_lo_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign cnt_lo    = cnt_reg[OFF_W-1:0];
    assign cnt_lo_m1 = cnt_lo - OFF_W'(1);

    // clearing sweep counter
    logic [ADDR_BITS-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
        end
    end

    // line memory write port
    logic [DATA_W-1:0] line_mem [LM_DEPTH];
    logic [DATA_W-1:0] lm_rd_data_reg;
    logic [DATA_W-1:0] st_rd_data_reg;
    logic              lm_we;
    logic [LM_W-1:0]   lm_waddr;
    logic [DATA_W-1:0] lm_wdata;
    logic [LM_W-1:0]   lm_raddr;

    always_comb
    begin
        lm_we    = 1'b0;
        lm_waddr = {req_line, req_off};
        lm_wdata = req_wdata_reg;
        priority if (cmd.clr_en)
        begin
            lm_we    = 1'b1;
            lm_waddr = clr_cnt_reg[LM_W-1:0];
            lm_wdata = '0;
        end
        else if (cmd.lm_wr_fill)
        begin
            lm_we    = 1'b1;
            lm_waddr = {req_line, cnt_lo_m1};
            lm_wdata = st_rd_data_reg;
        end
        else if (cmd.lm_wr_req)
        begin
            lm_we = 1'b1;
        end
        else
        begin
            lm_we = 1'b0;
        end
    end

    assign lm_raddr = cmd.lm_rd_walk ? {req_line, cnt_lo} : {req_line, req_off};

    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            line_mem[lm_waddr] <= lm_wdata;
        end
        if (cmd.lm_rd_en)
        begin
            lm_rd_data_reg <= line_mem[lm_raddr];
        end
    end

    // backing store memory
    logic [DATA_W-1:0]    store_mem [STORE_DEPTH];
    logic                 st_we;
    logic [ADDR_BITS-1:0] st_waddr;
    logic [DATA_W-1:0]    st_wdata;
    logic [ADDR_BITS-1:0] st_raddr;

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = {old_tag, req_line, cnt_lo_m1};
        st_wdata = lm_rd_data_reg;
        priority if (cmd.clr_en)
        begin
            st_we    = 1'b1;
            st_waddr = clr_cnt_reg;
            st_wdata = '0;
        end
        else if (cmd.st_wr_wb)
        begin
            st_we = 1'b1;
        end
        else
        begin
            st_we = 1'b0;
        end
    end

    assign st_raddr = {req_tag, req_line, cnt_lo};

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (cmd.st_rd_en)
        begin
            st_rd_data_reg <= store_mem[st_raddr];
        end
    end

    // output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_hit_reg;
    logic              out_dirty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg  <= lm_rd_data_reg;
            out_hit_reg   <= flag_hit_reg;
            out_dirty_reg <= flag_dirty_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign hit       = out_hit_reg;
    assign was_dirty = out_dirty_reg;

    // status back to the controller
    always_comb
    begin
        sts.clr_last = &clr_cnt_reg;
        sts.hit      = (old_tag == req_tag);
        sts.dirty    = dirty_reg[req_line];
        sts.is_write = (req_write_reg == REQ_WRITE);
        sts.cnt_zero = (cnt_reg == '0);
        sts.cnt_last = cnt_reg[OFF_W];
        sts.out_free = !out_valid_reg || out_ready;
    end

endmodule
